// ----- rtl/core/sts_pkg.sv -----
// Shared types, character codes and helper functions for the S-expression token scanner.
// Used by every module of the scanner; depends on nothing else.
`default_nettype none

package sts_pkg;

   localparam int PosWidth = 16;
   localparam int QueueDepth = 4;
   localparam int QueueIdxWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [PosWidth-1:0] PosMax = '1;
   localparam logic [PosWidth:0] LenOne = {{PosWidth{1'b0}}, 1'b1};

   localparam logic [3:0] KindOpen = 4'd0;
   localparam logic [3:0] KindClose = 4'd1;
   localparam logic [3:0] KindDot = 4'd2;
   localparam logic [3:0] KindQuote = 4'd3;
   localparam logic [3:0] KindBackquote = 4'd4;
   localparam logic [3:0] KindComma = 4'd5;
   localparam logic [3:0] KindString = 4'd6;
   localparam logic [3:0] KindUnterminated = 4'd7;
   localparam logic [3:0] KindSymbol = 4'd8;
   localparam logic [3:0] KindEnd = 4'd9;

   localparam logic [7:0] ChOpen = 8'h28;
   localparam logic [7:0] ChClose = 8'h29;
   localparam logic [7:0] ChDot = 8'h2E;
   localparam logic [7:0] ChQuote = 8'h27;
   localparam logic [7:0] ChBackquote = 8'h60;
   localparam logic [7:0] ChComma = 8'h2C;
   localparam logic [7:0] ChSemicolon = 8'h3B;
   localparam logic [7:0] ChDquote = 8'h22;
   localparam logic [7:0] ChNewline = 8'h0A;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTab = 8'h09;
   localparam logic [7:0] ChReturn = 8'h0D;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_flag;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start_pos;
      logic [15:0] length;
      logic        overflow;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } scan_push_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == ChSpace) || ((c >= ChTab) && (c <= ChReturn));
   endfunction

   function automatic logic is_sym(input logic [7:0] c);
      return !is_space(c) && (c != ChOpen) && (c != ChClose) && (c != ChDquote) &&
             (c != ChQuote) && (c != ChSemicolon) && (c != ChBackquote) && (c != ChComma);
   endfunction

   function automatic logic [15:0] to_field(input logic [PosWidth-1:0] p);
      logic [31:0] w;
      w = 32'(p);
      return w[15:0];
   endfunction

   function automatic rsp_type make_rec(input logic [3:0] kind,
                                        input logic [PosWidth-1:0] start,
                                        input logic [PosWidth:0] len,
                                        input logic ovf);
      rsp_type r;
      logic [PosWidth:0] sat;
      sat = (len > {1'b0, PosMax}) ? {1'b0, PosMax} : len;
      r.kind = kind;
      r.start_pos = to_field(start);
      r.length = to_field(sat[PosWidth-1:0]);
      r.overflow = ovf;
      r.last = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sexpr_token_scanner_unit.sv -----
// Top level of the S-expression token scanner: one text byte per request, token records out.
// Token records pass through the registered result queue to rsp, in order of arrival.
// Throughput: one request per cycle; a four-entry result queue absorbs the second record
// that a request may cause, and requests stall while more than two records wait.
// Reset clears the scanner state and empties the result queue. Depends on sts_pkg,
// sts_scan and sts_queue.
`default_nettype none

module sexpr_token_scanner_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sts_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sts_pkg::rsp_type      rsp_data
);

   logic                   take;
   sts_pkg::scan_push_type push;

   assign take = req_valid && !req_stall;

   sts_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_data (req_data),
      .push     (push)
   );

   sts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .push      (push),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .full      (req_stall)
   );

endmodule

`default_nettype wire

// ----- rtl/core/sts_scan.sv -----
// Scanner state and per-byte token decode for the S-expression token scanner.
// Depends on sts_pkg; produces up to two token records for each accepted request.
`default_nettype none

module sts_scan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire sts_pkg::req_type      req_data,
   output sts_pkg::scan_push_type     push
);

   localparam logic [1:0] ModeIdle = 2'd0;
   localparam logic [1:0] ModeComment = 2'd1;
   localparam logic [1:0] ModeString = 2'd2;
   localparam logic [1:0] ModeSymbol = 2'd3;

   logic [1:0]                  mode_ff, mode_in;
   logic [sts_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic [sts_pkg::PosWidth-1:0] start_ff, start_in;
   logic                        ovf_ff, ovf_in;

   logic                        at_max, ovf_next, has_a, has_b;
   logic [7:0]                  c;
   sts_pkg::rsp_type            rec_a, rec_b;

   always_comb begin
      c = req_data.char_in;
      at_max = (pos_ff == sts_pkg::PosMax);
      ovf_next = ovf_ff | at_max;
      mode_in = mode_ff;
      pos_in = pos_ff;
      start_in = start_ff;
      ovf_in = ovf_ff;
      rec_a = '0;
      rec_b = '0;
      has_a = 1'b0;
      has_b = 1'b0;

      if (req_data.end_flag) begin
         if ((mode_ff == ModeSymbol) || (mode_ff == ModeString)) begin
            has_a = 1'b1;
            rec_a = sts_pkg::make_rec((mode_ff == ModeSymbol) ? sts_pkg::KindSymbol
                                                               : sts_pkg::KindUnterminated,
                                      start_ff, {1'b0, pos_ff} - {1'b0, start_ff}, ovf_ff);
         end
         has_b = 1'b1;
         rec_b = sts_pkg::make_rec(sts_pkg::KindEnd, pos_ff, '0, ovf_ff);
         mode_in = ModeIdle;
         pos_in = '0;
         start_in = '0;
         ovf_in = 1'b0;
      end else begin
         pos_in = at_max ? pos_ff : pos_ff + 1'b1;
         ovf_in = ovf_next;
         case (mode_ff)
            ModeComment: begin
               if (c == sts_pkg::ChNewline) begin
                  mode_in = ModeIdle;
               end
            end
            ModeString: begin
               if (c == sts_pkg::ChDquote) begin
                  has_a = 1'b1;
                  rec_a = sts_pkg::make_rec(sts_pkg::KindString, start_ff,
                                            {1'b0, pos_ff} - {1'b0, start_ff} + sts_pkg::LenOne,
                                            ovf_next);
                  mode_in = ModeIdle;
               end
            end
            default: begin
               if (!((mode_ff == ModeSymbol) && sts_pkg::is_sym(c))) begin
                  if (mode_ff == ModeSymbol) begin
                     has_a = 1'b1;
                     rec_a = sts_pkg::make_rec(sts_pkg::KindSymbol, start_ff,
                                               {1'b0, pos_ff} - {1'b0, start_ff}, ovf_next);
                  end
                  mode_in = ModeIdle;
                  if (!sts_pkg::is_space(c)) begin
                     case (c)
                        sts_pkg::ChSemicolon: mode_in = ModeComment;
                        sts_pkg::ChOpen: begin
                           has_b = 1'b1;
                           rec_b = sts_pkg::make_rec(sts_pkg::KindOpen, pos_ff,
                                                     sts_pkg::LenOne, ovf_next);
                        end
                        sts_pkg::ChClose: begin
                           has_b = 1'b1;
                           rec_b = sts_pkg::make_rec(sts_pkg::KindClose, pos_ff,
                                                     sts_pkg::LenOne, ovf_next);
                        end
                        sts_pkg::ChDot: begin
                           has_b = 1'b1;
                           rec_b = sts_pkg::make_rec(sts_pkg::KindDot, pos_ff,
                                                     sts_pkg::LenOne, ovf_next);
                        end
                        sts_pkg::ChQuote: begin
                           has_b = 1'b1;
                           rec_b = sts_pkg::make_rec(sts_pkg::KindQuote, pos_ff,
                                                     sts_pkg::LenOne, ovf_next);
                        end
                        sts_pkg::ChBackquote: begin
                           has_b = 1'b1;
                           rec_b = sts_pkg::make_rec(sts_pkg::KindBackquote, pos_ff,
                                                     sts_pkg::LenOne, ovf_next);
                        end
                        sts_pkg::ChComma: begin
                           has_b = 1'b1;
                           rec_b = sts_pkg::make_rec(sts_pkg::KindComma, pos_ff,
                                                     sts_pkg::LenOne, ovf_next);
                        end
                        sts_pkg::ChDquote: begin
                           mode_in = ModeString;
                           start_in = pos_ff;
                        end
                        default: begin
                           mode_in = ModeSymbol;
                           start_in = pos_ff;
                        end
                     endcase
                  end
               end
            end
         endcase
      end

      push.count = {1'b0, has_a} + {1'b0, has_b};
      push.first = has_a ? rec_a : rec_b;
      push.second = rec_b;
      if (has_a && has_b) begin
         push.second.last = 1'b1;
      end else begin
         push.first.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeIdle;
         pos_ff <= '0;
         start_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (take) begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         start_ff <= start_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sts_queue.sv -----
// Scanner result queue: takes up to two records a cycle and gives one unless rsp is stalled.
// Depends on sts_pkg; the head entry is a register that drives the response port directly.
`default_nettype none

module sts_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire sts_pkg::scan_push_type push,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output sts_pkg::rsp_type           rsp_data,
   output logic                       full
);

   sts_pkg::rsp_type                   q_ff [sts_pkg::QueueDepth];
   sts_pkg::rsp_type                   q_in [sts_pkg::QueueDepth];
   logic [sts_pkg::QueueCntWidth-1:0]  cnt_ff, cnt_in, base;
   logic [sts_pkg::QueueIdxWidth-1:0]  idx0, idx1;
   logic [1:0]                         n_push;
   logic                               pop;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data = q_ff[0];
   assign full = (cnt_ff > sts_pkg::QueueCntWidth'(sts_pkg::QueueDepth - 2));
   assign pop = rsp_valid && !rsp_stall;

   always_comb begin
      q_in = q_ff;
      base = cnt_ff;
      if (pop) begin
         for (int i = 0; i < sts_pkg::QueueDepth - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
         base = cnt_ff - 1'b1;
      end
      n_push = take ? push.count : 2'd0;
      idx0 = base[sts_pkg::QueueIdxWidth-1:0];
      idx1 = idx0 + 1'b1;
      if (n_push != 2'd0) begin
         q_in[idx0] = push.first;
      end
      if (n_push == 2'd2) begin
         q_in[idx1] = push.second;
      end
      cnt_in = base + sts_pkg::QueueCntWidth'(n_push);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/sts_checker.sv -----
// Port-level checks for the S-expression token scanner, bound to its top level.
// Depends on sts_pkg and on the port list of sexpr_token_scanner_unit.
`default_nettype none

module sts_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire sts_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire sts_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Response valid dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("Response payload changed while stalled.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_end_queued: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.end_flag |=> rsp_valid)
      else $error("End of text request produced no response.");

   a_end_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == sts_pkg::KindEnd) |->
         rsp_data.last && (rsp_data.length == 16'd0))
      else $error("End token is not last or has nonzero length.");

endmodule

bind sexpr_token_scanner_unit sts_checker u_sts_checker (.*);

`default_nettype wire
